@@ sv/station_table_oldest_replace_core_assert.svh @@
// Assertion macros shared by the station table modules.
`ifndef STATION_TABLE_OLDEST_REPLACE_CORE_ASSERT_SVH
`define STATION_TABLE_OLDEST_REPLACE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define STOR_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("check failed in %m");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define STOR_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("check failed in %m");

`endif

@@ sv/stor_pkg.sv @@
// Types, codes and field widths shared by the station table modules.
package stor_pkg;

	localparam int STOR_CAPACITY = 64;

	localparam int ADDR_W   = 48;
	localparam int SIG_W    = 8;
	localparam int CHAN_W   = 8;
	localparam int TIME_W   = 32;
	localparam int SLOT_W   = 6;
	localparam int ECNT_W   = 7;
	localparam int MAX_W    = 7;
	localparam int LOCAL_BIT = 41;

	localparam int IN_DATA_W    = 144;
	localparam int IN_USER_W    = 2;
	localparam int OUT_FIELDS_W = SLOT_W + TIME_W + SIG_W + ECNT_W;
	localparam int OUT_DATA_W   = 56;
	localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;
	localparam int OUT_USER_W   = 3;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 7;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_ENTRIES  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_IGNORE_LOCAL = 1'b1;

	localparam logic [MAX_W-1:0] MAX_ENTRIES_RESET = 7'd64;

	typedef enum logic [1:0] {
		CMD_OBSERVE = 2'd0,
		CMD_LOOKUP  = 2'd1,
		CMD_CLEAR   = 2'd2,
		CMD_UNUSED  = 2'd3
	} stor_cmd_code_t;

	typedef enum logic [2:0] {
		ST_IGNORED   = 3'd0,
		ST_UPDATED   = 3'd1,
		ST_INSERTED  = 3'd2,
		ST_REPLACED  = 3'd3,
		ST_CLEARED   = 3'd4,
		ST_FOUND     = 3'd5,
		ST_NOT_FOUND = 3'd6
	} stor_status_t;

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_SCAN   = 3'b010,
		S_FINISH = 3'b100
	} stor_state_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;
		logic scan;
		logic finish;
	} stor_ctl_t;

	// Datapath to controller.
	typedef struct packed {
		logic needs_scan;
		logic scan_done;
		logic out_busy;
	} stor_sts_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [ADDR_W-1:0] network;
		logic [SIG_W-1:0]  signal;
		logic [CHAN_W-1:0] channel;
		logic [TIME_W-1:0] heard_at;
		logic [TIME_W-1:0] times;
	} stor_entry_t;

endpackage

@@ sv/stor_ctrl.sv @@
// Sequencing state machine for the station table: accept, scan, finish.
`include "station_table_oldest_replace_core_assert.svh"
module stor_ctrl
	import stor_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	output stor_ctl_t ctl,
	input  stor_sts_t sts
);

	stor_state_t state_q;
	stor_state_t state_d;

	assign s_tready   = (state_q == S_IDLE);
	assign ctl.load   = s_tvalid && s_tready;
	assign ctl.scan   = (state_q == S_SCAN);
	assign ctl.finish = (state_q == S_FINISH) && !sts.out_busy;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (ctl.load) begin
					state_d = sts.needs_scan ? S_SCAN : S_FINISH;
				end
			end
			S_SCAN: begin
				if (sts.scan_done) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (ctl.finish) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`STOR_ASSERT_NXT(a_load_leaves_idle, ctl.load, state_q != S_IDLE)
	`STOR_ASSERT_IMP(a_finish_has_room, ctl.finish, !sts.out_busy)
	`STOR_ASSERT_NXT(a_scan_holds, (state_q == S_SCAN) && !sts.scan_done, state_q == S_SCAN)

endmodule

@@ sv/stor_dp.sv @@
// Datapath of the station table: entry memory, scan, update and result register.
`include "station_table_oldest_replace_core_assert.svh"
module stor_dp
	import stor_pkg::*;
#(
	parameter int CAPACITY = STOR_CAPACITY
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic [IN_USER_W-1:0]  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic [OUT_USER_W-1:0] m_tuser,
	input  stor_ctl_t             ctl,
	output stor_sts_t             sts
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int LIM_W = (CNT_W > MAX_W) ? CNT_W : MAX_W;
	localparam logic [LIM_W-1:0] CAP_LIM = LIM_W'(CAPACITY);

	// Input fields.
	logic [ADDR_W-1:0] in_addr;
	logic [ADDR_W-1:0] in_net;
	logic [SIG_W-1:0]  in_sig;
	logic [CHAN_W-1:0] in_chan;
	logic [TIME_W-1:0] in_now;
	stor_cmd_code_t    in_cmd;
	logic              in_drop;

	assign in_addr = s_tdata[ADDR_W-1:0];
	assign in_net  = s_tdata[2*ADDR_W-1:ADDR_W];
	assign in_sig  = s_tdata[2*ADDR_W+SIG_W-1:2*ADDR_W];
	assign in_chan = s_tdata[2*ADDR_W+SIG_W+CHAN_W-1:2*ADDR_W+SIG_W];
	assign in_now  = s_tdata[IN_DATA_W-1:2*ADDR_W+SIG_W+CHAN_W];
	assign in_cmd  = stor_cmd_code_t'(s_tuser);

	// Configuration registers.
	logic [MAX_W-1:0] max_q;
	logic             ign_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MAX_ENTRIES_RESET;
			ign_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAX_ENTRIES:  max_q <= cfg_data;
				REG_IGNORE_LOCAL: ign_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign in_drop = ign_q && in_addr[LOCAL_BIT];
	assign sts.needs_scan = (in_cmd == CMD_LOOKUP) || ((in_cmd == CMD_OBSERVE) && !in_drop);

	// Held item.
	stor_cmd_code_t    cmd_q;
	logic              drop_q;
	logic [ADDR_W-1:0] addr_q;
	logic [ADDR_W-1:0] net_q;
	logic [SIG_W-1:0]  sig_q;
	logic [CHAN_W-1:0] chan_q;
	logic [TIME_W-1:0] now_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q  <= in_cmd;
			drop_q <= in_drop;
			addr_q <= in_addr;
			net_q  <= in_net;
			sig_q  <= in_sig;
			chan_q <= in_chan;
			now_q  <= in_now;
		end
	end

	// Entry memory: one write port, one registered read port.
	stor_entry_t       mem [CAPACITY];
	stor_entry_t       rdata_q;
	logic              rd_en;
	logic [IDX_W-1:0]  rd_addr;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_idx;
	stor_entry_t       wr_rec;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
		if (wr_en) begin
			mem[wr_idx] <= wr_rec;
		end
	end

	// Scan over valid entries, one read per cycle.
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  issue_idx_q;
	logic              rd_vld_s1;
	logic [IDX_W-1:0]  rd_idx_s1;
	logic              hit_q;
	logic [IDX_W-1:0]  hit_idx_q;
	logic [TIME_W-1:0] hit_times_q;
	logic [SIG_W-1:0]  hit_sig_q;
	logic [TIME_W-1:0] min_ls_q;
	logic [IDX_W-1:0]  min_idx_q;
	logic              more;
	logic              match_now;

	assign more      = issue_idx_q < cnt_q;
	assign match_now = rd_vld_s1 && !hit_q && (rdata_q.addr == addr_q);
	assign rd_en     = ctl.scan && more && !hit_q && !match_now;
	assign rd_addr   = issue_idx_q[IDX_W-1:0];
	assign sts.scan_done = ctl.scan && (hit_q || !more) && !rd_vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_idx_q <= '0;
			rd_vld_s1   <= 1'b0;
			hit_q       <= 1'b0;
		end else if (ctl.load) begin
			issue_idx_q <= '0;
			rd_vld_s1   <= 1'b0;
			hit_q       <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (rd_en) begin
				issue_idx_q <= CNT_W'(issue_idx_q + 1'b1);
			end
			if (match_now) begin
				hit_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_idx_s1 <= rd_addr;
		end
		if (match_now) begin
			hit_idx_q   <= rd_idx_s1;
			hit_times_q <= rdata_q.times;
			hit_sig_q   <= rdata_q.signal;
		end
		// The first entry seeds the minimum; ties keep the lower slot.
		if (rd_vld_s1 && ((rd_idx_s1 == '0) || (rdata_q.heard_at < min_ls_q))) begin
			min_ls_q  <= rdata_q.heard_at;
			min_idx_q <= rd_idx_s1;
		end
	end

	// Effective limit, clamped to one and to the capacity.
	logic [LIM_W-1:0] lim_raw;
	logic [LIM_W-1:0] limit;
	logic             room;

	assign lim_raw = LIM_W'(max_q);

	always_comb begin
		priority if (lim_raw == '0) begin
			limit = LIM_W'(1);
		end else if (lim_raw > CAP_LIM) begin
			limit = CAP_LIM;
		end else begin
			limit = lim_raw;
		end
	end

	assign room = LIM_W'(cnt_q) < limit;

	// Outcome of the held item.
	stor_status_t      fin_status;
	logic              fin_show;
	logic              fin_write;
	logic [IDX_W-1:0]  fin_slot;
	logic [TIME_W-1:0] fin_times;
	logic [SIG_W-1:0]  fin_sig;
	logic [CNT_W-1:0]  cnt_next;
	logic [TIME_W-1:0] times_inc;
	logic [SIG_W-1:0]  sig_best;

	assign times_inc = (hit_times_q == '1) ? hit_times_q : TIME_W'(hit_times_q + 1'b1);
	assign sig_best  = ($signed(sig_q) > $signed(hit_sig_q)) ? sig_q : hit_sig_q;

	always_comb begin
		fin_status = ST_IGNORED;
		fin_show   = 1'b0;
		fin_write  = 1'b0;
		fin_slot   = '0;
		fin_times  = '0;
		fin_sig    = '0;
		cnt_next   = cnt_q;
		unique case (cmd_q)
			CMD_CLEAR: begin
				fin_status = ST_CLEARED;
				cnt_next   = '0;
			end
			CMD_LOOKUP: begin
				if (hit_q) begin
					fin_status = ST_FOUND;
					fin_show   = 1'b1;
					fin_slot   = hit_idx_q;
					fin_times  = hit_times_q;
					fin_sig    = hit_sig_q;
				end else begin
					fin_status = ST_NOT_FOUND;
				end
			end
			CMD_OBSERVE: begin
				if (!drop_q) begin
					fin_show  = 1'b1;
					fin_write = 1'b1;
					priority if (hit_q) begin
						fin_status = ST_UPDATED;
						fin_slot   = hit_idx_q;
						fin_times  = times_inc;
						fin_sig    = sig_best;
					end else if (room) begin
						fin_status = ST_INSERTED;
						fin_slot   = cnt_q[IDX_W-1:0];
						fin_times  = TIME_W'(1);
						fin_sig    = sig_q;
						cnt_next   = CNT_W'(cnt_q + 1'b1);
					end else begin
						fin_status = ST_REPLACED;
						fin_slot   = min_idx_q;
						fin_times  = TIME_W'(1);
						fin_sig    = sig_q;
					end
				end
			end
			CMD_UNUSED: begin
				fin_status = ST_IGNORED;
			end
		endcase
	end

	assign wr_en  = ctl.finish && fin_write;
	assign wr_idx = fin_slot;
	assign wr_rec = '{addr: addr_q, network: net_q, signal: fin_sig, channel: chan_q,
		heard_at: now_q, times: fin_times};

	// Result register.
	logic              out_valid_q;
	stor_status_t      out_status_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic [TIME_W-1:0] out_times_q;
	logic [SIG_W-1:0]  out_sig_q;
	logic [ECNT_W-1:0] out_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else if (ctl.finish) begin
			out_valid_q <= 1'b1;
			cnt_q       <= cnt_next;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			out_status_q <= fin_status;
			out_slot_q   <= fin_show ? SLOT_W'(fin_slot) : '0;
			out_times_q  <= fin_times;
			out_sig_q    <= fin_sig;
			out_cnt_q    <= ECNT_W'(cnt_next);
		end
	end

	assign sts.out_busy = out_valid_q && !m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_cnt_q, out_sig_q, out_times_q, out_slot_q};

	`STOR_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(CAPACITY))
	`STOR_ASSERT_NXT(a_finish_shows, ctl.finish, out_valid_q)
	`STOR_ASSERT_IMP(a_hit_needs_entry, hit_q, hit_idx_q < cnt_q[IDX_W-1:0] || cnt_q == CNT_W'(CAPACITY))

endmodule

@@ sv/station_table_oldest_replace_core.sv @@
// Top level of the station table with oldest-entry replacement.
// Keeps up to CAPACITY stations keyed by 48-bit address in a single-port-read entry
// memory. Lookups and unfiltered observations scan the valid entries one per cycle,
// stopping at the first address match, or reading all of them on a miss. Clear, unused
// commands and filtered observations skip the scan. One item is worked on at a time;
// a finished result waits in an output register, and the next item is accepted while
// it does. The user must write configuration through cfg_we/cfg_index/cfg_data only
// while no transaction is in progress; the block itself does not enforce this.
module station_table_oldest_replace_core
	import stor_pkg::*;
#(
	parameter int CAPACITY = STOR_CAPACITY
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,   // 0 max_entries, 1 ignore_local
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// station_addr[47:0], network_addr[95:48], signal_dbm[103:96],
	// radio_channel[111:104], now_seconds[143:112]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic [IN_USER_W-1:0]  s_tuser,     // cmd[1:0]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// slot[5:0], seen_count[37:6], best_signal[45:38], entry_count[52:46], zeros above
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic [OUT_USER_W-1:0] m_tuser      // status[2:0]
);

	stor_ctl_t ctl;
	stor_sts_t sts;

	stor_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.ctl      (ctl),
		.sts      (sts)
	);

	stor_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.ctl       (ctl),
		.sts       (sts)
	);

endmodule
